/* src/fupp_pkg.sv */
`timescale 1ns / 1ps
// Shared types, character codes and decode helpers for the form pair parser.
// No dependencies.
package fupp_pkg;

  typedef enum logic [2:0] {
    KIND_KEY_BYTE = 3'd0,
    KIND_VAL_BYTE = 3'd1,
    KIND_KEY_END  = 3'd2,
    KIND_VAL_END  = 3'd3,
    KIND_DROPPED  = 3'd4
  } kind_e;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int unsigned RES_MAX  = 3;
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);

  // APB register map (word index)
  localparam logic REG_FORM_DECODE_ENABLE = 1'b0;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0]               count;
    result_t [RES_MAX-1:0]    res;
  } step_t;

  typedef struct packed {
    logic       value_phase;
    logic [1:0] esc_cnt;
    logic [7:0] first_hex;
  } parse_st_t;

  function automatic step_t push_res(step_t s, logic [7:0] d, kind_e k);
    step_t r;
    r = s;
    if (s.count != 2'd3) begin
      r.res[s.count].data = d;
      r.res[s.count].kind = k;
      r.res[s.count].last = 1'b0;
      r.count = s.count + 2'd1;
    end
    return r;
  endfunction

  function automatic logic [7:0] plain_byte(logic [7:0] c);
    return (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  // only leading hex digits count
  function automatic logic [7:0] escape_byte(logic [7:0] hi, logic [7:0] lo);
    logic [4:0] h;
    logic [4:0] l;
    logic [7:0] r;
    h = hex_val(hi);
    l = hex_val(lo);
    if (!h[4])      r = 8'd0;
    else if (!l[4]) r = {4'd0, h[3:0]};
    else            r = {h[3:0], l[3:0]};
    return r;
  endfunction

endpackage

/* src/fupp_step.sv */
`timescale 1ns / 1ps
// Per-byte decode: from parse state and one input byte, builds up to three
// result words and the next parse state. Uses fupp_pkg.
module fupp_step import fupp_pkg::*; (
  input  parse_st_t  st_i,
  input  logic       enable_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output parse_st_t  st_o,
  output step_t      step_o
);

  kind_e kind_byte;
  logic  ends;

  assign kind_byte = st_i.value_phase ? KIND_VAL_BYTE : KIND_KEY_BYTE;
  assign ends      = st_i.value_phase ? (byte_i == CH_AMP) : (byte_i == CH_EQ);

  always_comb begin
    step_t s;
    parse_st_t n;
    s = '0;
    n = st_i;
    if (!enable_i) begin
      n.esc_cnt = 2'd0;
      s = push_res(s, byte_i, KIND_VAL_BYTE);
      if (last_i) begin
        s = push_res(s, 8'd0, KIND_VAL_END);
        n.value_phase = 1'b0;
      end
    end else begin
      if (ends) begin
        // short escape: flush '%' and any held byte before the end marker
        if (st_i.esc_cnt != 2'd0) s = push_res(s, CH_PCT, kind_byte);
        if (st_i.esc_cnt[1])      s = push_res(s, plain_byte(st_i.first_hex), kind_byte);
        s = push_res(s, 8'd0, st_i.value_phase ? KIND_VAL_END : KIND_KEY_END);
        n.esc_cnt     = 2'd0;
        n.value_phase = ~st_i.value_phase;
        if (last_i && n.value_phase) s = push_res(s, 8'd0, KIND_VAL_END);
      end else begin
        unique case (st_i.esc_cnt)
          2'd0: begin
            if (byte_i == CH_PCT && !last_i) n.esc_cnt = 2'd1;
            else s = push_res(s, plain_byte(byte_i), kind_byte);
          end
          2'd1: begin
            if (last_i) begin
              s = push_res(s, CH_PCT, kind_byte);
              s = push_res(s, plain_byte(byte_i), kind_byte);
              n.esc_cnt = 2'd0;
            end else begin
              n.first_hex = byte_i;
              n.esc_cnt   = 2'd2;
            end
          end
          default: begin
            s = push_res(s, escape_byte(st_i.first_hex, byte_i), kind_byte);
            n.esc_cnt = 2'd0;
          end
        endcase
        if (last_i) s = push_res(s, 8'd0, st_i.value_phase ? KIND_VAL_END : KIND_DROPPED);
      end
      if (last_i) begin
        n.value_phase = 1'b0;
        n.esc_cnt     = 2'd0;
      end
    end
    if (s.count != 2'd0) s.res[s.count - 2'd1].last = 1'b1;
    st_o   = n;
    step_o = s;
  end

endmodule

/* src/fupp_rq.sv */
`timescale 1ns / 1ps
// Result queue: takes up to three words per cycle, hands out one per cycle
// unless stalled. Uses fupp_pkg.
module fupp_rq import fupp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  step_t   step_i,
  output logic    full_o,
  output logic    valid_o,
  input  logic    stall_i,
  output result_t head_o
);

  result_t             mem_q [RQ_DEPTH];
  logic [RQ_AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [RQ_AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [RQ_AW:0]      cnt_q, cnt_d;
  logic [1:0]          n_push;
  logic                pop;

  assign n_push  = push_i ? step_i.count : 2'd0;
  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && !stall_i;
  assign head_o  = mem_q[rd_ptr_q];
  // room for a full step only while at most one word waits
  assign full_o  = (cnt_q > (RQ_AW+1)'(RQ_DEPTH - RES_MAX));

  assign wr_ptr_d = wr_ptr_q + RQ_AW'(n_push);
  assign rd_ptr_d = rd_ptr_q + RQ_AW'(pop);
  assign cnt_d    = cnt_q + (RQ_AW+1)'(n_push) - (RQ_AW+1)'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < RES_MAX; i++) begin
      if (2'(i) < n_push) mem_q[RQ_AW'(wr_ptr_q + RQ_AW'(i))] <= step_i.res[i];
    end
  end

endmodule

/* src/form_urlencoded_pair_parser.sv */
`timescale 1ns / 1ps
// Throughput: 1 byte per cycle; each byte yields 0 to 3 words, written to the
// result queue when the byte is taken; one word leaves per cycle unless
// out_stall_i is set, and the 4-entry queue stalls input while 2 or more wait.
// Reset: parse state cleared, form decoding enabled, result queue empty.
// Depends on fupp_pkg, fupp_step, fupp_rq.
module form_urlencoded_pair_parser import fupp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic [2:0]  out_kind_o,
  output logic        out_last_o
);

  logic      enable_q;
  parse_st_t st_q, st_d;
  step_t     step;
  logic      rq_full;
  logic      accept;
  result_t   head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FORM_DECODE_ENABLE) ? {31'd0, enable_q} : 32'd0;

  assign in_stall_o = rq_full;
  assign accept     = in_valid_i && !rq_full;

  fupp_step u_step (
    .st_i     (st_q),
    .enable_i (enable_q),
    .byte_i   (in_byte_i),
    .last_i   (in_last_i),
    .st_o     (st_d),
    .step_o   (step)
  );

  fupp_rq u_rq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .step_i  (step),
    .full_o  (rq_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .head_o  (head)
  );

  assign out_byte_o = head.data;
  assign out_kind_o = head.kind;
  assign out_last_o = head.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      st_q     <= '0;
    end else begin
      if (psel && penable && pwrite && paddr[2] == REG_FORM_DECODE_ENABLE) begin
        enable_q <= pwdata[0];
      end
      if (accept) begin
        st_q <= st_d;
      end
    end
  end

endmodule
